[design/csd_pkg.sv]
// ----------------------------------------------------------------------------
// csd_pkg
// Types, constants and denomination table for the coin store change dispenser.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int NUM_SLOTS   = 8;
  localparam int SLOT_BITS   = 3;
  localparam int MAX_RESULTS = 64;
  localparam int N_BITS      = $clog2(MAX_RESULTS);
  localparam int CENTS_BITS  = 10;
  localparam int AMT_BITS    = 9;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DENOM = 2'd1;
  localparam logic [1:0] ST_NO_CHANGE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_CHANGE = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [CENTS_BITS-1:0] coin_cents;
    logic [AMT_BITS-1:0]   amount_cents;
  } csd_in_t;

  typedef struct packed {
    logic                 coin_valid;
    logic [SLOT_BITS-1:0] coin_index;
    logic [1:0]           status;
    logic                 last;
  } csd_res_t;

  typedef struct packed {
    logic                  we;
    logic [SLOT_BITS-1:0]  addr;
    logic [COUNT_BITS-1:0] data;
  } csd_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_CHG,
    S_FAIL
  } csd_state_e;

  function automatic logic [CENTS_BITS-1:0] slot_value(input logic [SLOT_BITS-1:0] idx);
    logic [CENTS_BITS-1:0] v;
    case (idx)
      3'd0:    v = 10'd5;
      3'd1:    v = 10'd10;
      3'd2:    v = 10'd20;
      3'd3:    v = 10'd50;
      3'd4:    v = 10'd100;
      3'd5:    v = 10'd200;
      3'd6:    v = 10'd500;
      3'd7:    v = 10'd1000;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

[design/coin_store_change_dispenser.sv]
// ----------------------------------------------------------------------------
// coin_store_change_dispenser
// Coin store with eight denomination counters and a greedy change dispenser.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. An add-coin word
// gives one result. A change word walks the slots from ten dollars down to
// five cents, one slot per cycle through a single compare/subtract unit,
// and walks them again after a pass that gave a coin; when change cannot be
// made it ends in a cannot-change result, and a zero amount gives one result
// with no coin. At most one coin result is produced per cycle. Each result is
// shown on res_o for one cycle with res_valid_o high and must be taken then;
// the result register lets the next word be accepted while the last result is on the port.
// ----------------------------------------------------------------------------
module coin_store_change_dispenser import csd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  csd_in_t  in_i,
  output logic     busy,
  output logic     res_valid_o,
  output csd_res_t res_o
);

  logic [SLOT_BITS-1:0]  rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  csd_wr_t               wr;
  logic [AMT_BITS-1:0]   alu_remain;
  logic [CENTS_BITS-1:0] alu_value;
  logic                  alu_fits;
  logic [AMT_BITS-1:0]   alu_diff;

  csd_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .in_i         (in_i),
    .busy_o       (busy),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_o         (wr),
    .alu_remain_o (alu_remain),
    .alu_value_o  (alu_value),
    .alu_fits_i   (alu_fits),
    .alu_diff_i   (alu_diff),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

  csd_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  csd_alu u_alu (
    .remain_i (alu_remain),
    .value_i  (alu_value),
    .fits_o   (alu_fits),
    .diff_o   (alu_diff)
  );

  a_coin_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.coin_valid |-> res_o.status == ST_OK)
    else $error("coin result with error status");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o && res_o.last)
    else $error("word finished without a last result");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("last result while still busy");

endmodule

[design/csd_alu.sv]
// ----------------------------------------------------------------------------
// csd_alu
// Shared compare/subtract unit: checks a coin value against the remaining
// amount and forms the new remainder.
// ----------------------------------------------------------------------------
module csd_alu import csd_pkg::*; (
  input  logic [AMT_BITS-1:0]   remain_i,
  input  logic [CENTS_BITS-1:0] value_i,
  output logic                  fits_o,
  output logic [AMT_BITS-1:0]   diff_o
);

  logic [CENTS_BITS-1:0] remain_ext;
  logic [CENTS_BITS-1:0] diff_ext;

  assign remain_ext = CENTS_BITS'(remain_i);
  assign diff_ext   = remain_ext - value_i;
  assign fits_o     = (value_i <= remain_ext);
  assign diff_o     = diff_ext[AMT_BITS-1:0];

endmodule

[design/csd_store.sv]
// ----------------------------------------------------------------------------
// csd_store
// Coin count register file, one read port and one write port.
// ----------------------------------------------------------------------------
module csd_store import csd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [SLOT_BITS-1:0]  rd_addr_i,
  output logic [COUNT_BITS-1:0] rd_data_o,
  input  csd_wr_t               wr_i
);

  logic [COUNT_BITS-1:0] count_q [NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        count_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      count_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = count_q[rd_addr_i];

endmodule

[design/csd_seq.sv]
// ----------------------------------------------------------------------------
// csd_seq
// Sequencer: decodes add-coin words and walks the slots for change requests.
// ----------------------------------------------------------------------------
module csd_seq import csd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  csd_in_t               in_i,
  output logic                  busy_o,
  output logic [SLOT_BITS-1:0]  rd_addr_o,
  input  logic [COUNT_BITS-1:0] rd_data_i,
  output csd_wr_t               wr_o,
  output logic [AMT_BITS-1:0]   alu_remain_o,
  output logic [CENTS_BITS-1:0] alu_value_o,
  input  logic                  alu_fits_i,
  input  logic [AMT_BITS-1:0]   alu_diff_i,
  output logic                  res_valid_o,
  output csd_res_t              res_o
);

  csd_state_e           state_q, state_d;
  logic [SLOT_BITS-1:0] slot_q, slot_d;
  logic                 hit_q, hit_d;
  logic [AMT_BITS-1:0]  remain_q, remain_d;
  logic [SLOT_BITS-1:0] idx_q, idx_d;
  logic [N_BITS-1:0]    n_q, n_d;
  logic                 gave_q, gave_d;
  logic                 res_valid_q, res_valid_d;
  csd_res_t             res_q, res_d;
  logic                 take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      n_q         <= '0;
      gave_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      n_q         <= n_d;
      gave_q      <= gave_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    hit_q    <= hit_d;
    remain_q <= remain_d;
    idx_q    <= idx_d;
    res_q    <= res_d;
  end

  assign rd_addr_o    = (state_q == S_ADD) ? slot_q : idx_q;
  assign alu_remain_o = remain_q;
  assign alu_value_o  = slot_value(idx_q);
  assign take         = (rd_data_i != '0) && alu_fits_i;

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    hit_d       = hit_q;
    remain_d    = remain_q;
    idx_d       = idx_q;
    n_d         = n_q;
    gave_d      = gave_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    wr_o        = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          hit_d  = 1'b0;
          slot_d = '0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (in_i.coin_cents == slot_value(SLOT_BITS'(i))) begin
              hit_d  = 1'b1;
              slot_d = SLOT_BITS'(i);
            end
          end
          remain_d = in_i.amount_cents;
          idx_d    = SLOT_BITS'(NUM_SLOTS - 1);
          n_d      = '0;
          gave_d   = 1'b0;
          state_d  = (in_i.operation == OP_CHANGE) ? S_CHG : S_ADD;
        end
      end

      S_ADD: begin
        res_valid_d      = 1'b1;
        res_d.coin_valid = 1'b0;
        res_d.coin_index = '0;
        res_d.last       = 1'b1;
        if (!hit_q) begin
          res_d.status = ST_BAD_DENOM;
        end else if (rd_data_i == COUNT_MAX) begin
          res_d.status = ST_FULL;
        end else begin
          res_d.status = ST_OK;
          wr_o.we      = 1'b1;
          wr_o.addr    = slot_q;
          wr_o.data    = rd_data_i + COUNT_BITS'(1);
        end
        state_d = S_IDLE;
      end

      S_CHG: begin
        if (remain_q == '0) begin
          res_valid_d      = 1'b1;
          res_d.coin_valid = 1'b0;
          res_d.coin_index = '0;
          res_d.status     = ST_OK;
          res_d.last       = 1'b1;
          state_d          = S_IDLE;
        end else begin
          if (take) begin
            wr_o.we          = 1'b1;
            wr_o.addr        = idx_q;
            wr_o.data        = rd_data_i - COUNT_BITS'(1);
            remain_d         = alu_diff_i;
            n_d              = n_q + N_BITS'(1);
            res_valid_d      = 1'b1;
            res_d.coin_valid = 1'b1;
            res_d.coin_index = idx_q;
            res_d.status     = ST_OK;
            res_d.last       = (alu_diff_i == '0);
          end
          if (take && (alu_diff_i == '0)) begin
            state_d = S_IDLE;
          end else if (take && (n_q == N_BITS'(MAX_RESULTS - 2))) begin
            state_d = S_FAIL;
          end else if (idx_q == '0) begin
            if (gave_q || take) begin
              idx_d  = SLOT_BITS'(NUM_SLOTS - 1);
              gave_d = 1'b0;
            end else begin
              state_d = S_FAIL;
            end
          end else begin
            idx_d  = idx_q - SLOT_BITS'(1);
            gave_d = gave_q | take;
          end
        end
      end

      S_FAIL: begin
        res_valid_d      = 1'b1;
        res_d.coin_valid = 1'b0;
        res_d.coin_index = '0;
        res_d.status     = ST_NO_CHANGE;
        res_d.last       = 1'b1;
        state_d          = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
